/* rtl/core/mexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, the modulus reset constant and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_W        = 63;
    localparam int EXP_IN_W      = 63;
    localparam int OUT_W         = 32;
    localparam int CFG_W         = 32;
    localparam int DIV_W         = 64;
    localparam int CNT_W         = 6;
    localparam int EXP_WIDTH_DEF = 63;
    localparam int MOD_WIDTH_DEF = 32;
    localparam logic [CFG_W-1:0] MOD_RESET = 32'd1000000007;

    typedef struct packed {
        logic load;
        logic mul_ld;
        logic mul_sq;
        logic red_step;
        logic wr_base;
        logic wr_acc;
        logic clr_acc;
        logic shift_e;
        logic out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic e_zero;
        logic e_lsb;
        logic mod_zero;
        logic red_last;
    } dp_sts_t;

endpackage

/* rtl/core/mexp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_in_if
// Request channel: base and exponent with valid/ready.
// ----------------------------------------------------------------------------
interface mexp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::BASE_W-1:0]  base;
    logic [mexp_pkg::EXP_IN_W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

/* rtl/core/mexp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_out_if
// Result channel: power_mod with valid/ready.
// ----------------------------------------------------------------------------
interface mexp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::OUT_W-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink (input valid, input power_mod, output ready);
endinterface

/* rtl/core/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
//
// Usage:
//   in_req (sink) takes one request: base and exponent. out_rsp (source)
//   returns power_mod for each request, in order. cfg_we/cfg_data write the
//   modulus; write it only while no request is in flight.
//   One request is worked on at a time. Every modular product is a multiply
//   loaded into the dividend register followed by a bit-serial remainder;
//   that reducer sets the rate. A zero exponent or zero modulus finishes
//   without any reduction; else the base is first reduced, then for each
//   exponent bit up to the highest set bit the accumulator is multiplied by
//   the base when the bit is set, and the base is squared.
//   The result sits in an output register; a new request is taken while it
//   waits, and the finished result then holds until the register frees.
//   Reset clears the sequencer and the output valid and sets the modulus to
//   1000000007.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mexp_in_if.sink                    in_req,
    mexp_out_if.source                 out_rsp,
    input  logic                       cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0] cfg_data
);
    import mexp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_req.valid),
        .in_ready  (in_req.ready),
        .out_valid (out_rsp.valid),
        .out_ready (out_rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mexp_dpath #(
        .EXP_WIDTH (EXP_WIDTH),
        .MOD_WIDTH (MOD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .base      (in_req.base),
        .exponent  (in_req.exponent),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .power_mod (out_rsp.power_mod)
    );

endmodule

/* rtl/core/mexp_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dpath
// Modulus register, operand registers, multiplier and bit-serial reducer.
// ----------------------------------------------------------------------------
module mexp_dpath #(
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mexp_pkg::dp_cmd_t             cmd,
    output mexp_pkg::dp_sts_t             sts,
    input  logic [mexp_pkg::BASE_W-1:0]   base,
    input  logic [mexp_pkg::EXP_IN_W-1:0] exponent,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0]    cfg_data,
    output logic [mexp_pkg::OUT_W-1:0]    power_mod
);
    import mexp_pkg::*;

    logic [MOD_WIDTH-1:0]   mod_reg;
    logic [MOD_WIDTH-1:0]   base_reg;
    logic [MOD_WIDTH-1:0]   acc_reg;
    logic [MOD_WIDTH-1:0]   rem_reg;
    logic [MOD_WIDTH-1:0]   out_reg;
    logic [EXP_WIDTH-1:0]   e_reg;
    logic [DIV_W-1:0]       div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [MOD_WIDTH:0]     rem_shift;
    logic [MOD_WIDTH:0]     rem_diff;
    logic [MOD_WIDTH-1:0]   rem_next;
    logic [MOD_WIDTH-1:0]   mul_a;
    logic [2*MOD_WIDTH-1:0] product;
    logic [DIV_W-1:0]       exp_ext;

    assign rem_shift = {rem_reg, div_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, mod_reg};
    assign rem_next  = (rem_shift >= {1'b0, mod_reg}) ? rem_diff[MOD_WIDTH-1:0]
                                                      : rem_shift[MOD_WIDTH-1:0];
    assign mul_a     = cmd.mul_sq ? base_reg : acc_reg;
    assign product   = mul_a * base_reg;
    assign exp_ext   = {1'b0, exponent};

    assign sts.e_zero   = (e_reg == '0);
    assign sts.e_lsb    = e_reg[0];
    assign sts.mod_zero = (mod_reg == '0);
    assign sts.red_last = (cnt_reg == CNT_W'(DIV_W - 1));
    assign power_mod    = OUT_W'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MOD_RESET[MOD_WIDTH-1:0];
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mod_reg <= cfg_data[MOD_WIDTH-1:0];
            end
            if (cmd.load || cmd.mul_ld)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg <= {1'b0, base};
            rem_reg <= '0;
            e_reg   <= exp_ext[EXP_WIDTH-1:0];
            acc_reg <= MOD_WIDTH'(1);
        end
        else
        begin
            if (cmd.mul_ld)
            begin
                div_reg <= DIV_W'(product);
                rem_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                div_reg <= div_reg << 1;
                rem_reg <= rem_next;
            end
            if (cmd.wr_base)
            begin
                base_reg <= rem_next;
            end
            if (cmd.clr_acc)
            begin
                acc_reg <= '0;
            end
            else if (cmd.wr_acc)
            begin
                acc_reg <= rem_next;
            end
            if (cmd.shift_e)
            begin
                e_reg <= e_reg >> 1;
            end
        end
        if (cmd.out_ld)
        begin
            out_reg <= acc_reg;
        end
    end

endmodule

/* rtl/core/mexp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for base reduction and square-and-multiply steps; result handshake.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mexp_pkg::dp_cmd_t cmd,
    input  mexp_pkg::dp_sts_t sts
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_BRED,
        S_STEP,
        S_MULA,
        S_REDA,
        S_MULS,
        S_REDS
    } state_t;

    typedef enum logic {
        F_NONE,
        F_FIN
    } fin_t;

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE) && (fin_reg == F_NONE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fin_reg == F_FIN)
        begin
            if (out_free)
            begin
                cmd.out_ld     = 1'b1;
                out_valid_next = 1'b1;
                fin_next       = F_NONE;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (sts.e_zero)
                    begin
                        fin_next   = F_FIN;
                        state_next = S_IDLE;
                    end
                    else if (sts.mod_zero)
                    begin
                        cmd.clr_acc = 1'b1;
                        fin_next    = F_FIN;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BRED;
                    end
                end
                S_BRED:
                begin
                    cmd.red_step = 1'b1;
                    if (sts.red_last)
                    begin
                        cmd.wr_base = 1'b1;
                        state_next  = S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (sts.e_zero)
                    begin
                        fin_next   = F_FIN;
                        state_next = S_IDLE;
                    end
                    else if (sts.e_lsb)
                    begin
                        state_next = S_MULA;
                    end
                    else
                    begin
                        state_next = S_MULS;
                    end
                end
                S_MULA:
                begin
                    cmd.mul_ld = 1'b1;
                    state_next = S_REDA;
                end
                S_REDA:
                begin
                    cmd.red_step = 1'b1;
                    if (sts.red_last)
                    begin
                        cmd.wr_acc = 1'b1;
                        state_next = S_MULS;
                    end
                end
                S_MULS:
                begin
                    cmd.mul_ld = 1'b1;
                    cmd.mul_sq = 1'b1;
                    state_next = S_REDS;
                end
                S_REDS:
                begin
                    cmd.red_step = 1'b1;
                    if (sts.red_last)
                    begin
                        cmd.wr_base = 1'b1;
                        cmd.shift_e = 1'b1;
                        state_next  = S_STEP;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= F_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/mexp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on request acceptance, result stability and the zero-exponent result.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [mexp_pkg::EXP_IN_W-1:0] exponent,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mexp_pkg::OUT_W-1:0]    power_mod
);
    import mexp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_mod))
        else $error("result dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && exponent == '0
        |-> ##3 out_valid && power_mod == OUT_W'(1))
        else $error("zero exponent did not return one");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .exponent  (in_req.exponent),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .power_mod (out_rsp.power_mod)
);
